>>> sv/p521_field_square_radix58_top_macros.svh
// assertion macros for the p521 squaring pipeline
`ifndef P521_FIELD_SQUARE_RADIX58_TOP_MACROS_SVH
`define P521_FIELD_SQUARE_RADIX58_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define P521SQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define P521SQ_ASSERT_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define P521SQ_ASSERT(label, prop, msg)
`define P521SQ_ASSERT_NR(label, prop, msg)
`endif
`endif

>>> sv/p521sq_pkg.sv
package p521sq_pkg;

   localparam int NUM_LIMBS = 9;
   localparam int RADIX     = 58;
   localparam int TOP_W     = 57;
   localparam int OPND_W    = RADIX + 1;
   localparam int LO_W      = 30;
   localparam int HI_W      = OPND_W - LO_W;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int NUM_PAIRS = NUM_LIMBS * (NUM_LIMBS + 1) / 2;
   localparam int NUM_COLS  = 2 * NUM_LIMBS - 1;
   // folded column stays below 17 products of 118 bits
   localparam int COL_W     = 123;
   localparam int H_W       = COL_W - RADIX;
   localparam int T_W       = H_W + 1;
   localparam int TC_W      = T_W - RADIX;
   localparam int E_W       = H_W + 1;
   localparam int RUN_W     = E_W + 2;
   localparam int WIDE_W    = NUM_LIMBS * RADIX + 1;

   typedef struct packed {
      logic [RADIX-1:0] in_limb_0;
      logic [RADIX-1:0] in_limb_1;
      logic [RADIX:0]   in_limb_2;
      logic [RADIX-1:0] in_limb_3;
      logic [RADIX-1:0] in_limb_4;
      logic [RADIX-1:0] in_limb_5;
      logic [RADIX-1:0] in_limb_6;
      logic [RADIX-1:0] in_limb_7;
      logic [TOP_W-1:0] in_limb_8;
   } req_word_type;

   typedef struct packed {
      logic [RADIX-1:0] out_limb_0;
      logic [RADIX-1:0] out_limb_1;
      logic [RADIX:0]   out_limb_2;
      logic [RADIX-1:0] out_limb_3;
      logic [RADIX-1:0] out_limb_4;
      logic [RADIX-1:0] out_limb_5;
      logic [RADIX-1:0] out_limb_6;
      logic [RADIX-1:0] out_limb_7;
      logic [TOP_W-1:0] out_limb_8;
   } rsp_word_type;

   // all limbs carried at the width of the widest one
   typedef logic [NUM_LIMBS-1:0][OPND_W-1:0] opnd_vec_type;

   typedef struct packed {
      logic [2*LO_W-1:0]      ll;
      logic [LO_W+HI_W-1:0]   lh;
      logic [LO_W+HI_W-1:0]   hl;
      logic [2*HI_W-1:0]      hh;
   } pp_type;

   typedef pp_type [NUM_PAIRS-1:0]             pp_vec_type;
   typedef logic [NUM_PAIRS-1:0][PROD_W-1:0]   prod_vec_type;
   typedef logic [NUM_COLS-1:0][COL_W-1:0]     col_vec_type;
   typedef logic [NUM_LIMBS-1:0][COL_W-1:0]    fold_vec_type;

endpackage

>>> sv/p521sq_if.sv
interface p521sq_req_if;
   import p521sq_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface p521sq_rsp_if;
   import p521sq_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

>>> sv/p521_field_square_radix58_top.sv
// p521 field squaring, nine limbs in radix 2^58
// throughput: one word per cycle while the response side is ready, every stage is fully pipelined
// the rate follows the output register handshake alone
// reset: synchronous, active high, clears all stage valid bits; payload is not reset
module p521_field_square_radix58_top (
   input  logic          clock,
   input  logic          reset,
   p521sq_req_if.sink    req_chan,
   p521sq_rsp_if.source  rsp_chan
);
   import p521sq_pkg::*;

   // stage map
   //   1-2  partial products of 30-bit halves, then full limb products
   //   3-4  column sums of the square, then fold of the upper columns
   //   5-7  carry pass in three rounds, ending with one wide add
   //   8    wrap of the top carry into limbs 0..2, output register
   // each stage moves when it is empty or the stage after it moves,
   // so bubbles collapse and a word waiting at the output does not
   // block new request words while the pipe has room

   opnd_vec_type opnd;
   logic         mult_valid, mult_ready;
   prod_vec_type mult_prod;
   logic         col_valid, col_ready;
   fold_vec_type col_fold;
   logic         carry_valid, carry_ready;
   opnd_vec_type carry_res;
   logic [RUN_W-1:0] carry_run;

   // operand limbs widened to a common width
   assign opnd[0] = OPND_W'(req_chan.word.in_limb_0);
   assign opnd[1] = OPND_W'(req_chan.word.in_limb_1);
   assign opnd[2] = req_chan.word.in_limb_2;
   assign opnd[3] = OPND_W'(req_chan.word.in_limb_3);
   assign opnd[4] = OPND_W'(req_chan.word.in_limb_4);
   assign opnd[5] = OPND_W'(req_chan.word.in_limb_5);
   assign opnd[6] = OPND_W'(req_chan.word.in_limb_6);
   assign opnd[7] = OPND_W'(req_chan.word.in_limb_7);
   assign opnd[8] = OPND_W'(req_chan.word.in_limb_8);

   p521sq_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_opnd   (opnd),
      .out_valid (mult_valid),
      .out_ready (mult_ready),
      .out_prod  (mult_prod)
   );

   p521sq_column u_column (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mult_valid),
      .in_ready  (mult_ready),
      .in_prod   (mult_prod),
      .out_valid (col_valid),
      .out_ready (col_ready),
      .out_fold  (col_fold)
   );

   p521sq_carry u_carry (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (col_valid),
      .in_ready  (col_ready),
      .in_fold   (col_fold),
      .out_valid (carry_valid),
      .out_ready (carry_ready),
      .out_res   (carry_res),
      .out_run   (carry_run)
   );

   // output register sits here; rsp channel is driven straight from it
   p521sq_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (carry_valid),
      .in_ready  (carry_ready),
      .in_res    (carry_res),
      .in_run    (carry_run),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (rsp_chan.word)
   );

endmodule

>>> sv/p521sq_mult.sv
module p521sq_mult (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  p521sq_pkg::opnd_vec_type  in_opnd,
   output logic                      out_valid,
   input  logic                      out_ready,
   output p521sq_pkg::prod_vec_type  out_prod
);
   import p521sq_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   logic         s2_valid_ff, s2_valid_in;
   logic         s1_en, s2_en;
   pp_vec_type   pp_ff, pp_in;
   prod_vec_type prod_ff, prod_in;

   assign s2_en = !s2_valid_ff || out_ready;
   assign s1_en = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   assign s1_valid_in = s1_en ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;

   // one product per unordered limb pair, four partial products each
   for (genvar gi = 0; gi < NUM_LIMBS; gi++) begin : g_row
      for (genvar gj = gi; gj < NUM_LIMBS; gj++) begin : g_col
         localparam int P = gi * NUM_LIMBS - (gi * (gi - 1)) / 2 + (gj - gi);
         logic [LO_W-1:0] a_lo, b_lo;
         logic [HI_W-1:0] a_hi, b_hi;
         logic [PROD_W-1:0] mid;

         assign a_lo = in_opnd[gi][LO_W-1:0];
         assign a_hi = in_opnd[gi][OPND_W-1:LO_W];
         assign b_lo = in_opnd[gj][LO_W-1:0];
         assign b_hi = in_opnd[gj][OPND_W-1:LO_W];

         assign pp_in[P].ll = (2*LO_W)'(a_lo) * (2*LO_W)'(b_lo);
         assign pp_in[P].lh = (LO_W+HI_W)'(a_lo) * (LO_W+HI_W)'(b_hi);
         assign pp_in[P].hl = (LO_W+HI_W)'(a_hi) * (LO_W+HI_W)'(b_lo);
         assign pp_in[P].hh = (2*HI_W)'(a_hi) * (2*HI_W)'(b_hi);

         assign mid = PROD_W'(pp_ff[P].lh) + PROD_W'(pp_ff[P].hl);
         assign prod_in[P] = {pp_ff[P].hh, {(2*LO_W){1'b0}}} + (mid << LO_W)
                             + PROD_W'(pp_ff[P].ll);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         pp_ff <= pp_in;
      end
      if (s2_en) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_prod  = prod_ff;

endmodule

>>> sv/p521sq_column.sv
module p521sq_column (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  p521sq_pkg::prod_vec_type  in_prod,
   output logic                      out_valid,
   input  logic                      out_ready,
   output p521sq_pkg::fold_vec_type  out_fold
);
   import p521sq_pkg::*;

   logic         s3_valid_ff, s3_valid_in;
   logic         s4_valid_ff, s4_valid_in;
   logic         s3_en, s4_en;
   col_vec_type  col_ff, col_in;
   fold_vec_type fold_ff, fold_in;

   assign s4_en = !s4_valid_ff || out_ready;
   assign s3_en = !s3_valid_ff || s4_en;
   assign in_ready = s3_en;

   assign s3_valid_in = s3_en ? in_valid : s3_valid_ff;
   assign s4_valid_in = s4_en ? s3_valid_ff : s4_valid_ff;

   // column sums, cross products counted twice
   always_comb begin
      int n;
      col_in = '0;
      n = 0;
      for (int i = 0; i < NUM_LIMBS; i++) begin
         for (int j = i; j < NUM_LIMBS; j++) begin
            if (i == j) begin
               col_in[i+j] = col_in[i+j] + COL_W'(in_prod[n]);
            end else begin
               col_in[i+j] = col_in[i+j] + COL_W'({in_prod[n], 1'b0});
            end
            n = n + 1;
         end
      end
   end

   // 2^522 = 2 mod p: upper columns fold down doubled
   always_comb begin
      for (int i = 0; i < NUM_LIMBS - 1; i++) begin
         fold_in[i] = col_ff[i] + {col_ff[i+NUM_LIMBS][COL_W-2:0], 1'b0};
      end
      fold_in[NUM_LIMBS-1] = col_ff[NUM_LIMBS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         col_ff <= col_in;
      end
      if (s4_en) begin
         fold_ff <= fold_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_fold  = fold_ff;

endmodule

>>> sv/p521sq_carry.sv
`include "p521_field_square_radix58_top_macros.svh"

module p521sq_carry (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  p521sq_pkg::fold_vec_type         in_fold,
   output logic                             out_valid,
   input  logic                             out_ready,
   output p521sq_pkg::opnd_vec_type         out_res,
   output logic [p521sq_pkg::RUN_W-1:0]     out_run
);
   import p521sq_pkg::*;

   typedef logic [NUM_LIMBS-1:0][T_W-1:0] t_vec_type;

   logic              s5_valid_ff, s5_valid_in;
   logic              s6_valid_ff, s6_valid_in;
   logic              s7_valid_ff, s7_valid_in;
   logic              s5_en, s6_en, s7_en;
   t_vec_type         t_ff, t_in;
   logic [H_W-1:0]    e1_ff, e1_in;
   opnd_vec_type      u_ff, u_in;
   logic [E_W-1:0]    e2_ff, e2_in;
   logic [E_W-1:0]    e3;
   logic [WIDE_W-1:0] wide_a, wide_b, wide_sum;
   opnd_vec_type      res_ff, res_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [NUM_LIMBS-1:0] u_small;

   assign s7_en = !s7_valid_ff || out_ready;
   assign s6_en = !s6_valid_ff || s7_en;
   assign s5_en = !s5_valid_ff || s6_en;
   assign in_ready = s5_en;

   assign s5_valid_in = s5_en ? in_valid : s5_valid_ff;
   assign s6_valid_in = s6_en ? s5_valid_ff : s6_valid_ff;
   assign s7_valid_in = s7_en ? s6_valid_ff : s7_valid_ff;

   // first round: each column's high part moves one limb up
   always_comb begin
      t_in[0] = T_W'(in_fold[0][RADIX-1:0]);
      for (int i = 1; i < NUM_LIMBS; i++) begin
         t_in[i] = T_W'(in_fold[i][RADIX-1:0]) + T_W'(in_fold[i-1][COL_W-1:RADIX]);
      end
      e1_in = in_fold[NUM_LIMBS-1][COL_W-1:RADIX];
   end

   // second round: carries now a few bits each
   always_comb begin
      u_in[0] = OPND_W'(t_ff[0][RADIX-1:0]);
      for (int i = 1; i < NUM_LIMBS; i++) begin
         u_in[i] = OPND_W'(t_ff[i][RADIX-1:0]) + OPND_W'(t_ff[i-1][T_W-1:RADIX]);
      end
      e2_in = E_W'(e1_ff) + E_W'(t_ff[NUM_LIMBS-1][T_W-1:RADIX]);
   end

   // last round: single-bit carries resolved by one wide add
   always_comb begin
      wide_a = '0;
      wide_b = '0;
      for (int i = 0; i < NUM_LIMBS; i++) begin
         wide_a[RADIX*i +: RADIX] = u_ff[i][RADIX-1:0];
      end
      for (int i = 0; i < NUM_LIMBS - 1; i++) begin
         wide_b[RADIX*(i+1)] = u_ff[i][RADIX];
      end
      wide_sum = wide_a + wide_b;
      for (int i = 0; i < NUM_LIMBS - 1; i++) begin
         res_in[i] = OPND_W'(wide_sum[RADIX*i +: RADIX]);
      end
      res_in[NUM_LIMBS-1] = OPND_W'(wide_sum[RADIX*(NUM_LIMBS-1) +: TOP_W]);
      e3 = e2_ff + E_W'(u_ff[NUM_LIMBS-1][RADIX]);
      // everything above bit 520, with the 2^522 overflow counted twice
      run_in = RUN_W'({e3, 1'b0}) + RUN_W'(wide_sum[WIDE_W-1:WIDE_W-2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
         s7_valid_ff <= s7_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_en) begin
         t_ff  <= t_in;
         e1_ff <= e1_in;
      end
      if (s6_en) begin
         u_ff  <= u_in;
         e2_ff <= e2_in;
      end
      if (s7_en) begin
         res_ff <= res_in;
         run_ff <= run_in;
      end
   end

   assign out_valid = s7_valid_ff;
   assign out_res   = res_ff;
   assign out_run   = run_ff;

   // a limb that carries out must have a tiny low part
   always_comb begin
      for (int i = 0; i < NUM_LIMBS; i++) begin
         u_small[i] = !u_ff[i][RADIX] || (u_ff[i][RADIX-1:TC_W] == '0);
      end
   end

   `P521SQ_ASSERT(a_carry_bits_small, s6_valid_ff |-> (&u_small), "second carry round too wide")
   `P521SQ_ASSERT(a_stall_holds, s7_valid_ff && !out_ready |=> s7_valid_ff && $stable(res_ff) && $stable(run_ff), "stalled word changed")
   `P521SQ_ASSERT(a_bubble_fills, !s7_valid_ff && s6_valid_ff |=> s7_valid_ff, "bubble not collapsed")
   `P521SQ_ASSERT_NR(a_reset_clears, reset |=> !s5_valid_ff && !s6_valid_ff && !s7_valid_ff, "valid left after reset")

endmodule

>>> sv/p521sq_wrap.sv
`include "p521_field_square_radix58_top_macros.svh"

module p521sq_wrap (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  p521sq_pkg::opnd_vec_type      in_res,
   input  logic [p521sq_pkg::RUN_W-1:0]  in_run,
   output logic                          out_valid,
   input  logic                          out_ready,
   output p521sq_pkg::rsp_word_type      out_word
);
   import p521sq_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 en;
   rsp_word_type         word_ff, word_in;
   logic [RUN_W:0]       sum0;
   logic [OPND_W-1:0]    sum1;

   assign en = !valid_ff || out_ready;
   assign in_ready = en;
   assign valid_in = en ? in_valid : valid_ff;

   // top carry wraps into limb 0, then ripples through limbs 1 and 2
   always_comb begin
      sum0 = (RUN_W+1)'(in_res[0][RADIX-1:0]) + (RUN_W+1)'(in_run);
      sum1 = OPND_W'(in_res[1][RADIX-1:0]) + OPND_W'(sum0[RUN_W:RADIX]);
      word_in.out_limb_0 = sum0[RADIX-1:0];
      word_in.out_limb_1 = sum1[RADIX-1:0];
      word_in.out_limb_2 = in_res[2] + OPND_W'(sum1[RADIX]);
      word_in.out_limb_3 = in_res[3][RADIX-1:0];
      word_in.out_limb_4 = in_res[4][RADIX-1:0];
      word_in.out_limb_5 = in_res[5][RADIX-1:0];
      word_in.out_limb_6 = in_res[6][RADIX-1:0];
      word_in.out_limb_7 = in_res[7][RADIX-1:0];
      word_in.out_limb_8 = in_res[8][TOP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   `P521SQ_ASSERT(a_limb2_bound, valid_ff |-> (!word_ff.out_limb_2[RADIX] || word_ff.out_limb_2[RADIX-1:0] == '0), "limb 2 above 2^58")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

// squaring in GF(2^521-1), nine limbs in radix 2^58
// a queue of operands feeds a bursty driver, a monitor with its own stall
// pattern checks every response word against a local predictor
module testbench;
   import p521sq_pkg::*;

   localparam logic [63:0] MASK58 = 64'h03ff_ffff_ffff_ffff;
   localparam logic [63:0] MASK57 = 64'h01ff_ffff_ffff_ffff;
   localparam logic [63:0] LIMB2_CHAIN = 64'h0400_0000_0000_0000;  // 2^58
   localparam int LATENCY = 8;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;

   p521sq_req_if req_chan ();
   p521sq_rsp_if rsp_chan ();

   p521_field_square_radix58_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   req_word_type pending_operands[$];    // operands not yet sent
   rsp_word_type expected_squares[$];    // predicted squares, oldest first
   int mismatch_count;
   int response_count;
   int cycle_count;

   // sender burst state
   int burst_left;
   int gap_left;

   // receiver stall state
   int stall_mode;
   int stall_mode_left;

   // --------------------------------------------------------------------
   // limb access by index
   // --------------------------------------------------------------------
   function automatic logic [63:0] req_limb(input req_word_type w, input int k);
      case (k)
         0: return 64'(w.in_limb_0);
         1: return 64'(w.in_limb_1);
         2: return 64'(w.in_limb_2);
         3: return 64'(w.in_limb_3);
         4: return 64'(w.in_limb_4);
         5: return 64'(w.in_limb_5);
         6: return 64'(w.in_limb_6);
         7: return 64'(w.in_limb_7);
         default: return 64'(w.in_limb_8);
      endcase
   endfunction

   function automatic logic [63:0] rsp_limb(input rsp_word_type w, input int k);
      case (k)
         0: return 64'(w.out_limb_0);
         1: return 64'(w.out_limb_1);
         2: return 64'(w.out_limb_2);
         3: return 64'(w.out_limb_3);
         4: return 64'(w.out_limb_4);
         5: return 64'(w.out_limb_5);
         6: return 64'(w.out_limb_6);
         7: return 64'(w.out_limb_7);
         default: return 64'(w.out_limb_8);
      endcase
   endfunction

   // bits above the field width are dropped
   function automatic req_word_type set_limb(input req_word_type w, input int k,
                                             input logic [63:0] v);
      req_word_type r;
      r = w;
      case (k)
         0: r.in_limb_0 = v[RADIX-1:0];
         1: r.in_limb_1 = v[RADIX-1:0];
         2: r.in_limb_2 = v[RADIX:0];
         3: r.in_limb_3 = v[RADIX-1:0];
         4: r.in_limb_4 = v[RADIX-1:0];
         5: r.in_limb_5 = v[RADIX-1:0];
         6: r.in_limb_6 = v[RADIX-1:0];
         7: r.in_limb_7 = v[RADIX-1:0];
         default: r.in_limb_8 = v[TOP_W-1:0];
      endcase
      return r;
   endfunction

   function automatic req_word_type fill_limbs(input logic [63:0] v);
      req_word_type r;
      r = '0;
      for (int k = 0; k < NUM_LIMBS; k++) r = set_limb(r, k, v);
      return r;
   endfunction

   function automatic logic [63:0] rand_word64();
      return {$urandom, $urandom};
   endfunction

   // every limb random over its full field width
   function automatic req_word_type rand_full_operand();
      req_word_type r;
      r = '0;
      for (int k = 0; k < NUM_LIMBS; k++) r = set_limb(r, k, rand_word64());
      return r;
   endfunction

   // limbs within their nominal range, limb 2 sometimes at 2^58
   function automatic req_word_type rand_nominal_operand();
      req_word_type r;
      r = '0;
      for (int k = 0; k < NUM_LIMBS; k++) r = set_limb(r, k, rand_word64() & MASK58);
      if ($urandom_range(0, 7) == 0) r.in_limb_2 = LIMB2_CHAIN[RADIX:0];
      return r;
   endfunction

   // --------------------------------------------------------------------
   // predictor: exact column sums, fold with factor 2, one carry pass,
   // wrap of the top carry into limb 0 and a ripple through limbs 1 and 2
   // --------------------------------------------------------------------
   function automatic rsp_word_type square_mod_p(input req_word_type x);
      logic [127:0] opnd[NUM_LIMBS];
      logic [127:0] col[2*NUM_LIMBS-1];
      logic [127:0] acc;
      logic [127:0] carry;
      logic [127:0] shifted;
      logic [63:0]  res[NUM_LIMBS];
      logic [63:0]  rip;
      rsp_word_type y;
      for (int k = 0; k < NUM_LIMBS; k++) opnd[k] = {64'b0, req_limb(x, k)};
      for (int k = 0; k < 2*NUM_LIMBS-1; k++) col[k] = '0;
      for (int i = 0; i < NUM_LIMBS; i++)
         for (int j = 0; j < NUM_LIMBS; j++)
            col[i+j] = col[i+j] + opnd[i] * opnd[j];
      // 2^522 is 2 mod p
      for (int i = NUM_LIMBS; i < 2*NUM_LIMBS-1; i++)
         col[i-NUM_LIMBS] = col[i-NUM_LIMBS] + (col[i] << 1);
      carry = '0;
      for (int i = 0; i < NUM_LIMBS; i++) begin
         acc = col[i] + carry;
         if (i == NUM_LIMBS-1) begin
            res[i] = acc[63:0] & MASK57;
            carry = acc >> TOP_W;
         end else begin
            res[i] = acc[63:0] & MASK58;
            carry = acc >> RADIX;
         end
      end
      // top carry wraps into limb 0
      acc = {64'b0, res[0]} + carry;
      res[0] = acc[63:0] & MASK58;
      shifted = acc >> RADIX;
      rip = shifted[63:0];
      res[1] = res[1] + rip;
      rip = res[1] >> RADIX;
      res[1] = res[1] & MASK58;
      res[2] = res[2] + rip;
      y.out_limb_0 = res[0][RADIX-1:0];
      y.out_limb_1 = res[1][RADIX-1:0];
      y.out_limb_2 = res[2][RADIX:0];
      y.out_limb_3 = res[3][RADIX-1:0];
      y.out_limb_4 = res[4][RADIX-1:0];
      y.out_limb_5 = res[5][RADIX-1:0];
      y.out_limb_6 = res[6][RADIX-1:0];
      y.out_limb_7 = res[7][RADIX-1:0];
      y.out_limb_8 = res[8][TOP_W-1:0];
      return y;
   endfunction

   // --------------------------------------------------------------------
   // clock and the cycle limit
   // --------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // driver: bursts of random length separated by random gaps
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      logic next_valid;
      req_word_type next_word;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         // a word accepted at this edge gets its square predicted
         if (req_chan.valid && req_chan.ready)
            expected_squares.push_back(square_mod_p(req_chan.word));
         // a word offered but not taken is held unchanged
         if (!req_chan.valid || req_chan.ready) begin
            next_valid = 1'b0;
            next_word = req_chan.word;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_operands.size() > 0) begin
               next_valid = 1'b1;
               next_word = pending_operands.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  // some bursts run straight into the next one
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_chan.valid <= next_valid;
            req_chan.word <= next_word;
         end
      end
   end

   // --------------------------------------------------------------------
   // monitor: checks response words and drives its own stall pattern
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      logic bad;
      logic next_ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_squares.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected response word %0d: %h", response_count, rsp_chan.word);
            mismatch_count++;
         end else begin
            want = expected_squares.pop_front();
            bad = 1'b0;
            for (int k = 0; k < NUM_LIMBS; k++) begin
               if (rsp_limb(rsp_chan.word, k) !== rsp_limb(want, k)) begin
                  if (mismatch_count < 10)
                     $display("response word %0d limb %0d: expected %h actual %h",
                              response_count, k, rsp_limb(want, k),
                              rsp_limb(rsp_chan.word, k));
                  bad = 1'b1;
               end
            end
            if (bad) mismatch_count++;
         end
         response_count++;
      end
      // stall pattern changes every so often
      if (stall_mode_left <= 0) begin
         stall_mode = $urandom_range(0, 4);
         stall_mode_left = $urandom_range(8, 80);
      end else begin
         stall_mode_left--;
      end
      case (stall_mode)
         0: next_ready = 1'b1;                             // no back-pressure
         1: next_ready = ($urandom_range(0, 3) != 0);      // light stalls
         2: next_ready = ($urandom_range(0, 3) == 0);      // heavy stalls
         3: next_ready = (cycle_count % 5 != 0);           // periodic
         default: next_ready = (stall_mode_left % 12 < 3); // long stalls
      endcase
      rsp_chan.ready <= next_ready;
   end

   // --------------------------------------------------------------------
   // stimulus and end of run
   // --------------------------------------------------------------------
   initial begin
      req_word_type w;
      req_word_type chain_value;
      int chain_left;
      int kind;
      logic [63:0] v;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.word = '0;
      rsp_chan.ready = 1'b0;
      mismatch_count = 0;
      response_count = 0;
      cycle_count = 0;
      burst_left = 1;
      gap_left = 0;
      stall_mode = 0;
      stall_mode_left = 0;

      // zero, one and two
      pending_operands.push_back(fill_limbs(64'd0));
      pending_operands.push_back(set_limb(fill_limbs(64'd0), 0, 64'd1));
      pending_operands.push_back(set_limb(fill_limbs(64'd0), 0, 64'd2));
      // every field all ones, limb 2 at its full 59 bits
      pending_operands.push_back(fill_limbs('1));
      // the modulus itself, and p - 1
      w = fill_limbs(MASK58);
      pending_operands.push_back(w);
      pending_operands.push_back(set_limb(w, 0, MASK58 - 1));
      // limb 2 at 2^58 as left by a previous square
      pending_operands.push_back(set_limb(fill_limbs(64'd0), 2, LIMB2_CHAIN));
      pending_operands.push_back(set_limb(fill_limbs(MASK58), 2, LIMB2_CHAIN));
      // 2^260 squares to the top bit, 2^261 squares to 2 after the fold
      pending_operands.push_back(set_limb(fill_limbs(64'd0), 4, 64'd1 << 28));
      pending_operands.push_back(set_limb(fill_limbs(64'd0), 4, 64'd1 << 29));
      // top bit of every limb, and alternating patterns
      w = '0;
      for (int k = 0; k < NUM_LIMBS; k++)
         w = set_limb(w, k, (k == NUM_LIMBS-1) ? 64'd1 << (TOP_W-1) : 64'd1 << (RADIX-1));
      pending_operands.push_back(w);
      pending_operands.push_back(fill_limbs(64'haaaa_aaaa_aaaa_aaaa));
      pending_operands.push_back(fill_limbs(64'h5555_5555_5555_5555));
      // each limb alone at its maximum
      for (int k = 0; k < NUM_LIMBS; k++)
         pending_operands.push_back(set_limb(fill_limbs(64'd0), k, '1));

      // random part, partly chains of squarings that feed each result back
      chain_value = rand_nominal_operand();
      chain_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1: w = rand_full_operand();
            2, 3: w = rand_nominal_operand();
            4: begin
               // sparse: about half of the limbs zero
               w = rand_full_operand();
               for (int k = 0; k < NUM_LIMBS; k++)
                  if ($urandom_range(0, 1) == 0) w = set_limb(w, k, 64'd0);
            end
            5: begin
               // near the top: all ones with up to three bits knocked out
               w = ($urandom_range(0, 1) == 0) ? fill_limbs('1) : fill_limbs(MASK58);
               for (int m = $urandom_range(0, 3); m > 0; m--) begin
                  int k;
                  k = $urandom_range(0, NUM_LIMBS-1);
                  v = req_limb(w, k) & ~(64'd1 << $urandom_range(0, TOP_W-1));
                  w = set_limb(w, k, v);
               end
            end
            default: begin
               if (chain_left <= 0) begin
                  chain_value = rand_nominal_operand();
                  chain_left = $urandom_range(4, 30);
               end
               w = chain_value;
               chain_value = req_word_type'(square_mod_p(chain_value));
               chain_left--;
            end
         endcase
         pending_operands.push_back(w);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // everything sent, then everything answered
      @(negedge clock);
      while (pending_operands.size() > 0 || req_chan.valid) @(negedge clock);
      while (expected_squares.size() > 0) @(negedge clock);
      // catch any stray words after the last one
      repeat (4 * LATENCY) @(posedge clock);

      if (mismatch_count == 0 && expected_squares.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/p521sq_pkg.sv
sv/p521sq_if.sv
sv/p521sq_mult.sv
sv/p521sq_column.sv
sv/p521sq_carry.sv
sv/p521sq_wrap.sv
sv/p521_field_square_radix58_top.sv
sim/testbench.sv
